### hdl/kcv_pkg.sv
// ----------------------------------------------------------------------------
// kcv_pkg: shared definitions for the constant-velocity Kalman predictor
// Widths, function codes, microcode routing and the noise register bundle.
// ----------------------------------------------------------------------------
`default_nettype none
package kcv_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int TIME_WIDTH  = 20;
   localparam int NOISE_WIDTH = 31;
   localparam int WORK_WIDTH  = 48;
   localparam int MUL_A_WIDTH = 40;
   localparam int MUL_B_WIDTH = 32;
   localparam int PROD_WIDTH  = MUL_A_WIDTH + MUL_B_WIDTH;

   // Working store: 16 covariance entries followed by 4 state elements.
   localparam int NUM_ENTRIES = 20;
   localparam int STATE_BASE  = 16;
   localparam int NUM_TEMPS   = 9;
   localparam int NUM_OPS     = 27;

   localparam logic [1:0] FUNC_LOAD_STATE = 2'd0;
   localparam logic [1:0] FUNC_LOAD_COV   = 2'd1;
   localparam logic [1:0] FUNC_PREDICT    = 2'd2;

   // Microcode steps.
   localparam logic [4:0] OP_DT2   = 5'd0;
   localparam logic [4:0] OP_DT3H  = 5'd1;
   localparam logic [4:0] OP_DT4Q  = 5'd2;
   localparam logic [4:0] OP_Q00   = 5'd3;
   localparam logic [4:0] OP_Q02   = 5'd4;
   localparam logic [4:0] OP_Q22   = 5'd5;
   localparam logic [4:0] OP_Q11   = 5'd6;
   localparam logic [4:0] OP_Q13   = 5'd7;
   localparam logic [4:0] OP_Q33   = 5'd8;
   localparam logic [4:0] OP_FP    = 5'd9;
   localparam logic [4:0] OP_AFT   = 5'd17;
   localparam logic [4:0] OP_STATE = 5'd25;
   localparam logic [4:0] OP_LAST  = 5'd26;

   localparam logic [4:0] OUT_LAST = 5'd19;

   localparam logic CSR_NOISE_X = 1'b0;
   localparam logic CSR_NOISE_Y = 1'b1;

   typedef struct packed {
      logic [4:0] src;
      logic [4:0] dst;
   } route_type;

   typedef struct packed {
      logic [NOISE_WIDTH-1:0] x;
      logic [NOISE_WIDTH-1:0] y;
   } noise_type;

   // Source and destination entries of the matrix and state update steps.
   function automatic route_type op_route(input logic [4:0] op);
      route_type r;
      logic [4:0] k;
      r = '0;
      k = '0;
      if (op >= OP_STATE) begin
         r.dst = 5'(STATE_BASE) + (op - OP_STATE);
         r.src = r.dst + 5'd2;
      end else if (op >= OP_AFT) begin
         k     = op - OP_AFT;
         r.dst = {1'b0, k[2:1], 1'b0, k[0]};
         r.src = r.dst + 5'd2;
      end else if (op >= OP_FP) begin
         r.dst = op - OP_FP;
         r.src = r.dst + 5'd8;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### hdl/kcv_if.sv
// ----------------------------------------------------------------------------
// kcv_req_if / kcv_rsp_if: valid-ready channels of the predictor
// Request words carry loads and predicts; response words carry results.
// ----------------------------------------------------------------------------
`default_nettype none
interface kcv_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [3:0]         entry_index;
   logic signed [31:0] load_value;
   logic [19:0]        time_step;
   modport source (output valid, func, entry_index, load_value, time_step, input ready);
   modport sink   (input valid, func, entry_index, load_value, time_step, output ready);
endinterface

interface kcv_rsp_if;
   logic               valid;
   logic               ready;
   logic               result_kind;
   logic [3:0]         result_index;
   logic signed [31:0] result_value;
   logic               saturated;
   logic               last;
   modport source (output valid, result_kind, result_index, result_value, saturated, last,
                   input ready);
   modport sink   (input valid, result_kind, result_index, result_value, saturated, last,
                   output ready);
endinterface
`default_nettype wire

### hdl/kalman_cv_predict.sv
// ----------------------------------------------------------------------------
// kalman_cv_predict: prediction step of a 2D constant-velocity Kalman filter
// A load word is written into the store from the idle state. A predict word
// runs 27 multiply steps, each an ST_MUL and an ST_ACC state, on the one
// shared multiplier and then hands out its 20 result words, waiting on ready.
// No new request is taken until the last result word of a predict is issued.
// Reset clears the state vector and covariance to zero and the noise to 9.0.
// ----------------------------------------------------------------------------
`default_nettype none
module kalman_cv_predict (
   input  wire logic        clock,
   input  wire logic        reset,
   kcv_req_if.sink          req_chan,
   kcv_rsp_if.source        rsp_chan,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   import kcv_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ACC, ST_OUT} state_type;

   localparam logic signed [WORK_WIDTH-1:0] SAT_HI = WORK_WIDTH'((64'sd1 <<< (VALUE_WIDTH - 1)) - 1);
   localparam logic signed [WORK_WIDTH-1:0] SAT_LO = -SAT_HI - WORK_WIDTH'(1);

   state_type                    state_ff;
   logic [4:0]                   op_ff;
   logic [4:0]                   out_ff;
   logic [TIME_WIDTH-1:0]        dt_ff;
   // Working store: covariance entries 0..15, state elements 16..19.
   logic signed [WORK_WIDTH-1:0] work_ff [NUM_ENTRIES];
   // Step products: dt2, dt3h, dt4q and the six process noise terms.
   logic signed [WORK_WIDTH-1:0] tmp_ff  [NUM_TEMPS];
   logic                         rsp_valid_ff;
   logic                         rsp_kind_ff;
   logic [3:0]                   rsp_index_ff;
   logic signed [VALUE_WIDTH-1:0] rsp_value_ff;
   logic                         rsp_sat_ff;
   logic                         rsp_last_ff;

   noise_type                    noise;
   route_type                    route;
   logic [4:0]                   rd_addr;
   logic signed [WORK_WIDTH-1:0] rd_data;
   logic signed [MUL_A_WIDTH-1:0] mul_a;
   logic signed [MUL_B_WIDTH-1:0] mul_b;
   logic [1:0]                   mul_shift;
   logic signed [WORK_WIDTH-1:0] rounded;
   logic [3:0]                   cov_index;
   logic signed [WORK_WIDTH-1:0] q_add;
   logic signed [WORK_WIDTH-1:0] sum_in;
   logic signed [WORK_WIDTH-1:0] value_in;
   logic                         clip_in;
   logic                         emit_in;
   logic signed [WORK_WIDTH-1:0] load_in;
   logic signed [MUL_B_WIDTH-1:0] dt_b;
   logic signed [MUL_B_WIDTH-1:0] nx_b;
   logic signed [MUL_B_WIDTH-1:0] ny_b;

   kcv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .noise       (noise)
   );

   kcv_mul_unit u_mul (
      .clock       (clock),
      .load        (state_ff == ST_MUL),
      .op_a        (mul_a),
      .op_b        (mul_b),
      .extra_shift (mul_shift),
      .rounded     (rounded)
   );

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_kind  = rsp_kind_ff;
   assign rsp_chan.result_index = rsp_index_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.saturated    = rsp_sat_ff;
   assign rsp_chan.last         = rsp_last_ff;

   assign route     = op_route(op_ff);
   assign cov_index = 4'(out_ff - 5'd4);
   assign dt_b      = MUL_B_WIDTH'(dt_ff);
   assign nx_b      = MUL_B_WIDTH'(noise.x);
   assign ny_b      = MUL_B_WIDTH'(noise.y);
   assign load_in   = WORK_WIDTH'(req_chan.load_value);

   // The store has one read port: the multiply step reads the source entry,
   // the accumulate step the destination, and the output step the entry being sent.
   always_comb begin
      case (state_ff)
         ST_ACC:  rd_addr = route.dst;
         ST_OUT:  rd_addr = (out_ff < 5'd4) ? 5'(STATE_BASE) + out_ff : {1'b0, cov_index};
         default: rd_addr = route.src;
      endcase
      rd_data = (rd_addr < 5'(NUM_ENTRIES)) ? work_ff[rd_addr] : '0;
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_shift = 2'd0;
      mul_b     = dt_b;
      mul_a     = rd_data[MUL_A_WIDTH-1:0];
      case (op_ff)
         OP_DT2:  mul_a = MUL_A_WIDTH'(dt_ff);
         OP_DT3H: begin
            mul_a     = tmp_ff[0][MUL_A_WIDTH-1:0];
            mul_shift = 2'd1;
         end
         OP_DT4Q: begin
            mul_a     = tmp_ff[0][MUL_A_WIDTH-1:0];
            mul_b     = tmp_ff[0][MUL_B_WIDTH-1:0];
            mul_shift = 2'd2;
         end
         OP_Q00: begin mul_a = tmp_ff[2][MUL_A_WIDTH-1:0]; mul_b = nx_b; end
         OP_Q02: begin mul_a = tmp_ff[1][MUL_A_WIDTH-1:0]; mul_b = nx_b; end
         OP_Q22: begin mul_a = tmp_ff[0][MUL_A_WIDTH-1:0]; mul_b = nx_b; end
         OP_Q11: begin mul_a = tmp_ff[2][MUL_A_WIDTH-1:0]; mul_b = ny_b; end
         OP_Q13: begin mul_a = tmp_ff[1][MUL_A_WIDTH-1:0]; mul_b = ny_b; end
         OP_Q33: begin mul_a = tmp_ff[0][MUL_A_WIDTH-1:0]; mul_b = ny_b; end
         default: ;
      endcase
   end

   // Process noise term added to each covariance entry on the way out.
   always_comb begin
      q_add = '0;
      if (out_ff >= 5'd4) begin
         case (cov_index)
            4'd0:          q_add = tmp_ff[3];
            4'd2, 4'd8:    q_add = tmp_ff[4];
            4'd10:         q_add = tmp_ff[5];
            4'd5:          q_add = tmp_ff[6];
            4'd7, 4'd13:   q_add = tmp_ff[7];
            4'd15:         q_add = tmp_ff[8];
            default:       q_add = '0;
         endcase
      end
      sum_in  = rd_data + q_add;
      clip_in = 1'b0;
      if (sum_in > SAT_HI) begin
         value_in = SAT_HI;
         clip_in  = 1'b1;
      end else if (sum_in < SAT_LO) begin
         value_in = SAT_LO;
         clip_in  = 1'b1;
      end else begin
         value_in = sum_in;
      end
      emit_in = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= '0;
         out_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_ENTRIES; i++) work_ff[i] <= '0;
      end else begin
         if (rsp_chan.ready && !emit_in) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  case (req_chan.func)
                     FUNC_LOAD_STATE: begin
                        if (req_chan.entry_index < 4'd4)
                           work_ff[5'(STATE_BASE) + {3'b0, req_chan.entry_index[1:0]}] <= load_in;
                     end
                     FUNC_LOAD_COV: work_ff[{1'b0, req_chan.entry_index}] <= load_in;
                     FUNC_PREDICT: begin
                        dt_ff    <= req_chan.time_step;
                        op_ff    <= OP_DT2;
                        state_ff <= ST_MUL;
                     end
                     default: ;
                  endcase
               end
            end
            ST_MUL: state_ff <= ST_ACC;
            ST_ACC: begin
               // Scalar steps fill the temporaries; matrix steps accumulate in place.
               if (op_ff < OP_FP) tmp_ff[op_ff[3:0]] <= rounded;
               else work_ff[route.dst] <= rd_data + rounded;
               if (op_ff == OP_LAST) begin
                  out_ff   <= '0;
                  state_ff <= ST_OUT;
               end else begin
                  op_ff    <= op_ff + 5'd1;
                  state_ff <= ST_MUL;
               end
            end
            ST_OUT: begin
               if (emit_in) begin
                  work_ff[rd_addr] <= value_in;
                  rsp_valid_ff     <= 1'b1;
                  rsp_kind_ff      <= (out_ff >= 5'd4);
                  rsp_index_ff     <= (out_ff < 5'd4) ? out_ff[3:0] : cov_index;
                  rsp_value_ff     <= value_in[VALUE_WIDTH-1:0];
                  rsp_sat_ff       <= clip_in;
                  rsp_last_ff      <= (out_ff == OUT_LAST);
                  if (out_ff == OUT_LAST) state_ff <= ST_IDLE;
                  else out_ff <= out_ff + 5'd1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

### hdl/kcv_csr.sv
// ----------------------------------------------------------------------------
// kcv_csr: APB-style noise registers
// Holds the x and y acceleration noise variances.
// ----------------------------------------------------------------------------
`default_nettype none
module kcv_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output kcv_pkg::noise_type noise
);
   import kcv_pkg::*;

   localparam logic [NOISE_WIDTH-1:0] NOISE_RESET = NOISE_WIDTH'(589824);

   noise_type noise_ff;
   logic      write_in;

   assign write_in   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign noise      = noise_ff;

   always_comb begin
      case (csr_paddr[2])
         CSR_NOISE_X: csr_prdata = {1'b0, noise_ff.x};
         CSR_NOISE_Y: csr_prdata = {1'b0, noise_ff.y};
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_ff.x <= NOISE_RESET;
         noise_ff.y <= NOISE_RESET;
      end else if (write_in) begin
         if (csr_paddr[2] == CSR_NOISE_X) noise_ff.x <= csr_pwdata[NOISE_WIDTH-1:0];
         else noise_ff.y <= csr_pwdata[NOISE_WIDTH-1:0];
      end
   end
endmodule
`default_nettype wire

### hdl/kcv_mul_unit.sv
// ----------------------------------------------------------------------------
// kcv_mul_unit: shared fixed-point multiplier
// Registers the exact product, then rounds it half up, shifting out the fraction bits plus a selectable extra shift.
// ----------------------------------------------------------------------------
`default_nettype none
module kcv_mul_unit (
   input  wire logic                                 clock,
   input  wire logic                                 load,
   input  wire logic signed [kcv_pkg::MUL_A_WIDTH-1:0] op_a,
   input  wire logic signed [kcv_pkg::MUL_B_WIDTH-1:0] op_b,
   input  wire logic [1:0]                           extra_shift,
   output logic signed [kcv_pkg::WORK_WIDTH-1:0]     rounded
);
   import kcv_pkg::*;

   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic [1:0]                   shift_ff;
   logic signed [PROD_WIDTH-1:0] sum_in;
   logic signed [PROD_WIDTH-1:0] shifted_in;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff  <= op_a * op_b;
         shift_ff <= extra_shift;
      end
   end

   always_comb begin
      sum_in     = prod_ff + (PROD_WIDTH'(1) << (FRAC_BITS - 1 + int'(shift_ff)));
      shifted_in = sum_in >>> (FRAC_BITS + int'(shift_ff));
      rounded    = shifted_in[WORK_WIDTH-1:0];
   end
endmodule
`default_nettype wire

### sim/kcv_checker.sv
// ----------------------------------------------------------------------------
// kcv_checker: result checker for the constant-velocity Kalman predictor
// Watches the request, response and register ports, keeps its own copy of
// the filter state, predicts every response word and compares field by field.
// ----------------------------------------------------------------------------
module kcv_checker (
   input  logic        clock,
   input  logic        reset,
   kcv_req_if.sink     req_mon,
   kcv_rsp_if.sink     rsp_mon,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          pending_words
);
   import kcv_pkg::*;

   typedef struct packed {
      logic               kind;
      logic [3:0]         index;
      logic signed [31:0] value;
      logic               sat;
      logic               last;
   } result_word_type;

   result_word_type  expected_words[$];
   logic signed [63:0] model_state[4];
   logic signed [63:0] model_cov[16];
   logic [30:0]      noise_x, noise_y;

   // Arithmetic right shift with rounding half toward plus infinity.
   function automatic logic signed [63:0] round_shift(logic signed [63:0] p, int s);
      logic signed [63:0] bias;
      bias = 64'sd1 <<< (s - 1);
      return (p + bias) >>> s;
   endfunction

   function automatic logic signed [63:0] fmul(logic signed [63:0] a, logic signed [63:0] b);
      return round_shift(a * b, FRAC_BITS);
   endfunction

   function automatic logic signed [63:0] clip32(logic signed [63:0] v, output logic c);
      c = 1'b0;
      if (v > 64'sd2147483647) begin
         c = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         c = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Applies one prediction to the local filter copy and queues its 20 words.
   task automatic run_prediction(logic [19:0] ts);
      logic signed [63:0] d, dt2, dt3h, dt4q, nx, ny, v;
      logic signed [63:0] q[16], a[16], b[16], nxt[4];
      logic               c;
      result_word_type    w;
      d    = {44'd0, ts};
      nx   = {33'd0, noise_x};
      ny   = {33'd0, noise_y};
      dt2  = fmul(d, d);
      dt3h = round_shift(dt2 * d, FRAC_BITS + 1);
      dt4q = round_shift(dt2 * dt2, FRAC_BITS + 2);
      foreach (q[i]) q[i] = 0;
      q[0]  = fmul(dt4q, nx);
      q[2]  = fmul(dt3h, nx);
      q[8]  = q[2];
      q[10] = fmul(dt2, nx);
      q[5]  = fmul(dt4q, ny);
      q[7]  = fmul(dt3h, ny);
      q[13] = q[7];
      q[15] = fmul(dt2, ny);
      for (int r = 0; r < 4; r++)
         for (int k = 0; k < 4; k++)
            a[r*4+k] = (r < 2) ? model_cov[r*4+k] + fmul(d, model_cov[(r+2)*4+k])
                               : model_cov[r*4+k];
      for (int r = 0; r < 4; r++)
         for (int k = 0; k < 4; k++)
            b[r*4+k] = (k < 2) ? a[r*4+k] + fmul(d, a[r*4+k+2]) : a[r*4+k];
      nxt[0] = model_state[0] + fmul(d, model_state[2]);
      nxt[1] = model_state[1] + fmul(d, model_state[3]);
      nxt[2] = model_state[2];
      nxt[3] = model_state[3];
      for (int r = 0; r < 4; r++) begin
         v = clip32(nxt[r], c);
         model_state[r] = v;
         w = '{1'b0, 4'(r), v[31:0], c, 1'b0};
         expected_words.push_back(w);
      end
      for (int r = 0; r < 16; r++) begin
         v = clip32(b[r] + q[r], c);
         model_cov[r] = v;
         w = '{1'b1, 4'(r), v[31:0], c, r == 15};
         expected_words.push_back(w);
      end
   endtask

   assign pending_words = expected_words.size();

   always @(posedge clock) begin
      result_word_type want;
      if (reset) begin
         foreach (model_state[i]) model_state[i] = 0;
         foreach (model_cov[i]) model_cov[i] = 0;
         noise_x = 31'd589824;
         noise_y = 31'd589824;
         fail_count = 0;
         expected_words.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == CSR_NOISE_X) noise_x = csr_pwdata[30:0];
            else noise_y = csr_pwdata[30:0];
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected result word index %0d", rsp_mon.result_index);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_mon.result_kind !== want.kind) begin
                  $error("result_kind: expected %0d, got %0d", want.kind, rsp_mon.result_kind);
                  fail_count++;
               end
               if (rsp_mon.result_index !== want.index) begin
                  $error("result_index: expected %0d, got %0d", want.index,
                         rsp_mon.result_index);
                  fail_count++;
               end
               if (rsp_mon.result_value !== want.value) begin
                  $error("result_value: expected %0d, got %0d", want.value,
                         rsp_mon.result_value);
                  fail_count++;
               end
               if (rsp_mon.saturated !== want.sat) begin
                  $error("saturated: expected %0d, got %0d", want.sat, rsp_mon.saturated);
                  fail_count++;
               end
               if (rsp_mon.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_mon.last);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.func)
               FUNC_LOAD_STATE: begin
                  if (req_mon.entry_index < 4)
                     model_state[req_mon.entry_index[1:0]] = req_mon.load_value;
               end
               FUNC_LOAD_COV: begin
                  model_cov[req_mon.entry_index] = req_mon.load_value;
               end
               FUNC_PREDICT: begin
                  run_prediction(req_mon.time_step);
               end
               default: ;
            endcase
         end
      end
   end
endmodule

### sim/kalman_cv_predict_test.sv
// ----------------------------------------------------------------------------
// kalman_cv_predict_test: testbench top for the Kalman predictor
// Drives loads and predicts with random gaps and response stalls, writes the
// noise registers between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module kalman_cv_predict_test;
   import kcv_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending_words;
   int          cycle_count;
   // Once set, the response side holds ready low for one long stretch.
   logic        hold_off_request;

   kcv_req_if req_chan ();
   kcv_rsp_if rsp_chan ();

   kalman_cv_predict dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   kcv_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan.sink),
      .rsp_mon       (rsp_chan.sink),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // A watchdog that fails the run if it takes far longer than a correct one.
   // Worst case per item: 20 results, each behind a random stall, plus gaps.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 400000) begin
            $display("[kalman_cv_predict] ERROR");
            $finish;
         end
      end
   end

   // The response side stalls a random number of cycles before every word,
   // and once holds off for a long stretch so the block backs up.
   initial begin
      int gap;
      bit held_once;
      held_once      = 1'b0;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request && !held_once) begin
            held_once = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (600) @(posedge clock);
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   // Offers one word and waits until it is accepted, then drops valid
   // only if a gap follows.
   task automatic send_word(logic [1:0] f, logic [3:0] idx, logic [31:0] val,
                            logic [19:0] ts, bit allow_gap);
      int gap;
      gap = (allow_gap && $urandom_range(0, 3) != 0) ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.func        <= f;
      req_chan.entry_index <= idx;
      req_chan.load_value  <= val;
      req_chan.time_step   <= ts;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic idle_request;
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Lets the block drain completely before a register write.
   task automatic wait_drained;
      idle_request();
      while (pending_words != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_noise(logic reg_sel, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Small random values keep most predictions out of saturation; a few
   // are full range to push the clipping path.
   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
         default: return 32'($signed($urandom_range(0, 24'h3FFFFF)) - 32'sh200000);
      endcase
   endfunction

   function automatic logic [19:0] rand_time();
      return ($urandom_range(0, 7) == 0) ? 20'($urandom()) : 20'($urandom_range(0, 20'h2FFFF));
   endfunction

   // Loads a random state vector and a random subset of covariance entries, then predicts ahead.
   task automatic random_track(int predicts);
      for (int i = 0; i < 4; i++)
         send_word(FUNC_LOAD_STATE, 4'(i), rand_value(), 20'($urandom()), 1'b1);
      for (int i = 0; i < 16; i++)
         if ($urandom_range(0, 1))
            send_word(FUNC_LOAD_COV, 4'(i), rand_value(), 20'($urandom()), 1'b1);
      for (int i = 0; i < predicts; i++)
         send_word(FUNC_PREDICT, 4'($urandom()), $urandom(), rand_time(), 1'b1);
   endtask

   initial begin
      reset                = 1'b1;
      hold_off_request     = 1'b0;
      req_chan.valid       = 1'b0;
      req_chan.func        = FUNC_LOAD_STATE;
      req_chan.entry_index = '0;
      req_chan.load_value  = '0;
      req_chan.time_step   = '0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: a predict from reset state, extreme loads, the ignored
      // state indexes and the unused function code, and the time extremes.
      send_word(FUNC_PREDICT, 4'd0, 32'd0, 20'd0, 1'b0);
      send_word(FUNC_LOAD_STATE, 4'd0, 32'h7FFF_FFFF, 20'd0, 1'b0);
      send_word(FUNC_LOAD_STATE, 4'd2, 32'h7FFF_FFFF, 20'd0, 1'b0);
      send_word(FUNC_LOAD_STATE, 4'd1, 32'h8000_0000, 20'd0, 1'b0);
      send_word(FUNC_LOAD_STATE, 4'd3, 32'h8000_0000, 20'd0, 1'b0);
      send_word(FUNC_LOAD_STATE, 4'd9, 32'h1234_5678, 20'd0, 1'b0);
      send_word(FUNC_LOAD_STATE, 4'd15, 32'hFFFF_FFFF, 20'd0, 1'b0);
      send_word(FUNC_LOAD_COV, 4'd0, 32'h0001_0000, 20'd0, 1'b0);
      send_word(FUNC_LOAD_COV, 4'd15, 32'h8000_0000, 20'd0, 1'b0);
      send_word(FUNC_LOAD_COV, 4'd10, 32'h7FFF_FFFF, 20'd0, 1'b0);
      send_word(2'd3, 4'd5, 32'hFFFF_FFFF, 20'hFFFFF, 1'b0);
      send_word(FUNC_PREDICT, 4'd0, 32'd0, 20'h10000, 1'b0);
      send_word(FUNC_PREDICT, 4'hF, 32'hFFFF_FFFF, 20'hFFFFF, 1'b0);
      send_word(FUNC_PREDICT, 4'd0, 32'd0, 20'd1, 1'b0);
      wait_drained();

      // Largest noise on both axes, then zero noise, then back to random.
      write_noise(CSR_NOISE_X, 32'hFFFF_FFFF);
      write_noise(CSR_NOISE_Y, 32'h7FFF_FFFF);
      random_track(3);
      wait_drained();
      write_noise(CSR_NOISE_X, 32'd0);
      write_noise(CSR_NOISE_Y, 32'd0);
      random_track(3);

      // Long response hold-off while the sender keeps offering words.
      hold_off_request <= 1'b1;
      @(posedge clock);
      for (int i = 0; i < 6; i++)
         send_word(FUNC_PREDICT, 4'd0, 32'd0, rand_time(), 1'b0);
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         write_noise(CSR_NOISE_X, $urandom());
         write_noise(CSR_NOISE_Y, $urandom_range(0, 32'h0010_0000));
         for (int t = 0; t < 2; t++) begin
            random_track(4);
            // Some noise words in between: ignored codes and stray loads.
            send_word(2'd3, 4'($urandom()), $urandom(), 20'($urandom()), 1'b1);
            send_word(FUNC_LOAD_STATE, 4'($urandom_range(4, 15)), $urandom(),
                      20'($urandom()), 1'b1);
         end
         wait_drained();
      end

      if (fail_count == 0) begin
         $display("[kalman_cv_predict] OK");
      end else begin
         $display("[kalman_cv_predict] ERROR");
      end
      $finish;
   end
endmodule

### filelist.f
hdl/kcv_pkg.sv
hdl/kcv_if.sv
hdl/kcv_csr.sv
hdl/kcv_mul_unit.sv
hdl/kalman_cv_predict.sv
sim/kcv_checker.sv
sim/kalman_cv_predict_test.sv
